### rtl/core/dsp_pkg.sv
package dsp_pkg;

   localparam int ANGLE_W    = 8;
   localparam int PULSE_W    = 16;
   localparam int ALPHA_W    = 9;
   localparam int THR_W      = 8;
   localparam int Q_SHIFT    = 8;
   localparam int Q8_W       = ANGLE_W + Q_SHIFT;
   localparam int ERR_W      = Q8_W + 1;
   localparam int PROD_W     = ERR_W + Q_SHIFT;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // serial gain multiply: one gain bit a cycle
   localparam int GAIN_STEPS = ALPHA_W;
   localparam int GAIN_CNT_W = $clog2(GAIN_STEPS);
   localparam logic [GAIN_CNT_W-1:0] GAIN_LAST = GAIN_CNT_W'(GAIN_STEPS - 1);

   // pulse unit: angle times span, then restoring divide by 180
   localparam int QUOT_W    = ANGLE_W + PULSE_W;
   localparam int MUL_STEPS = ANGLE_W;
   localparam int DIV_STEPS = QUOT_W;
   localparam int PU_CNT_W  = $clog2(DIV_STEPS);
   localparam logic [PU_CNT_W-1:0] MUL_LAST = PU_CNT_W'(MUL_STEPS - 1);
   localparam logic [PU_CNT_W-1:0] DIV_LAST = PU_CNT_W'(DIV_STEPS - 1);

   localparam logic [ANGLE_W-1:0] MAX_ANGLE_DEG   = 8'd180;
   localparam logic [ANGLE_W-1:0] RESET_ANGLE_DEG = 8'd90;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 9'd256;
   localparam logic [Q8_W-1:0]    MAX_ANGLE_Q8    = {MAX_ANGLE_DEG, {Q_SHIFT{1'b0}}};

   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd1000;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd2000;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd32;
   localparam logic [THR_W-1:0]   THR_RESET       = 8'd1;

   localparam logic [1:0] REQ_TARGET = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_DIRECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GAIN,
      ST_MOVE,
      ST_PULSE
   } ctl_state_type;

   typedef enum logic [1:0] {
      PU_IDLE,
      PU_MUL,
      PU_DIV,
      PU_DONE
   } pu_state_type;

   typedef struct packed {
      logic               start;
      logic               ack;
      logic [ANGLE_W-1:0] angle;
   } pu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pu_sts_type;

endpackage

### rtl/core/dsp_req_if.sv
interface dsp_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [dsp_pkg::ANGLE_W-1:0] angle_deg;

   modport source (output valid, output req_type, output angle_deg, input ready);
   modport sink   (input valid, input req_type, input angle_deg, output ready);
endinterface

### rtl/core/dsp_rsp_if.sv
interface dsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dsp_pkg::PULSE_W-1:0] pulse_us;
   logic                        settled;

   modport source (output valid, output pulse_us, output settled, input ready);
   modport sink   (input valid, input pulse_us, input settled, output ready);
endinterface

### rtl/core/dsp_csr_if.sv
interface dsp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dsp_pkg::CSR_IDX_W-1:0]  index;
   logic [dsp_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/dsp_pulse_unit.sv
module dsp_pulse_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  dsp_pkg::pu_ctl_type         ctl,
   input  logic [dsp_pkg::PULSE_W-1:0] min_pulse,
   input  logic [dsp_pkg::PULSE_W-1:0] max_pulse,
   output dsp_pkg::pu_sts_type         sts,
   output logic [dsp_pkg::PULSE_W-1:0] pulse_us
);

   dsp_pkg::pu_state_type state_ff, state_in;

   logic [dsp_pkg::PU_CNT_W-1:0] cnt_ff, cnt_in;
   logic [dsp_pkg::QUOT_W-1:0]   mcand_ff, mcand_in;
   logic [dsp_pkg::ANGLE_W-1:0]  mplier_ff, mplier_in;
   logic [dsp_pkg::QUOT_W-1:0]   acc_ff, acc_in;
   logic [dsp_pkg::ANGLE_W-1:0]  rem_ff, rem_in;
   logic [dsp_pkg::PULSE_W-1:0]  min_ff, min_in;

   logic [dsp_pkg::PULSE_W-1:0]  span;
   logic [dsp_pkg::ANGLE_W:0]    trial;
   logic [dsp_pkg::ANGLE_W:0]    trial_sub;
   logic                         trial_ge;

   // inverted range saturates the span to zero
   assign span = (max_pulse >= min_pulse) ? (max_pulse - min_pulse) : '0;

   assign trial     = {rem_ff, acc_ff[dsp_pkg::QUOT_W-1]};
   assign trial_ge  = (trial >= {1'b0, dsp_pkg::MAX_ANGLE_DEG});
   assign trial_sub = trial - {1'b0, dsp_pkg::MAX_ANGLE_DEG};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsp_pkg::PU_IDLE: if (ctl.start) state_in = dsp_pkg::PU_MUL;
         dsp_pkg::PU_MUL:  if (cnt_ff == dsp_pkg::MUL_LAST) state_in = dsp_pkg::PU_DIV;
         dsp_pkg::PU_DIV:  if (cnt_ff == dsp_pkg::DIV_LAST) state_in = dsp_pkg::PU_DONE;
         dsp_pkg::PU_DONE: if (ctl.ack) state_in = dsp_pkg::PU_IDLE;
         default:          state_in = dsp_pkg::PU_IDLE;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      min_in    = min_ff;
      unique case (state_ff)
         dsp_pkg::PU_IDLE: begin
            if (ctl.start) begin
               mcand_in  = {{dsp_pkg::ANGLE_W{1'b0}}, span};
               mplier_in = ctl.angle;
               acc_in    = '0;
               min_in    = min_pulse;
               cnt_in    = '0;
            end
         end
         dsp_pkg::PU_MUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[dsp_pkg::QUOT_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[dsp_pkg::ANGLE_W-1:1]};
            rem_in    = '0;
            cnt_in    = (cnt_ff == dsp_pkg::MUL_LAST) ? '0 : cnt_ff + 1'b1;
         end
         dsp_pkg::PU_DIV: begin
            // one quotient bit a cycle, shifted in behind the dividend
            rem_in = trial_ge ? trial_sub[dsp_pkg::ANGLE_W-1:0] : trial[dsp_pkg::ANGLE_W-1:0];
            acc_in = {acc_ff[dsp_pkg::QUOT_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         dsp_pkg::PU_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.busy = (state_ff != dsp_pkg::PU_IDLE);
      sts.done = (state_ff == dsp_pkg::PU_DONE);
      pulse_us = min_ff + acc_ff[dsp_pkg::PULSE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsp_pkg::PU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      min_ff    <= min_in;
   end

endmodule

### rtl/core/damped_servo_pulse_control.sv
// an item with no result ends on acceptance; a direct request goes straight to the pulse unit,
// a settling tick passes the check first, a moving tick the check, gain multiply and move
// throughput: one item at a time, the next accepted once the result is in the output register
// cost set by the serial gain multiply and the pulse unit's multiply and divide
// reset: synchronous, active high; registers back to defaults, angle 90 degrees, damping idle
module damped_servo_pulse_control (
   input logic        clock,
   input logic        reset,
   dsp_req_if.sink    req,
   dsp_rsp_if.source  rsp,
   dsp_csr_if.sink    csr
);

   dsp_pkg::ctl_state_type state_ff, state_in;

   logic [dsp_pkg::PULSE_W-1:0]    min_ff, max_ff;
   logic [dsp_pkg::ALPHA_W-1:0]    alpha_ff;
   logic [dsp_pkg::THR_W-1:0]      thr_ff;

   logic [dsp_pkg::Q8_W-1:0]       cur_ff, cur_in;
   logic [dsp_pkg::ANGLE_W-1:0]    tgt_ff, tgt_in;
   logic                           damping_ff, damping_in;
   logic                           settled_ff, settled_in;

   logic [dsp_pkg::PROD_W-1:0]     mcand_ff, mcand_in;
   logic [dsp_pkg::ALPHA_W-1:0]    mplier_ff, mplier_in;
   logic [dsp_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [dsp_pkg::GAIN_CNT_W-1:0] cnt_ff, cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dsp_pkg::PULSE_W-1:0]    rsp_pulse_ff, rsp_pulse_in;
   logic                           rsp_settled_ff, rsp_settled_in;

   logic                           req_fire;
   logic                           load_rsp;
   logic [dsp_pkg::ANGLE_W-1:0]    ang_clamp;
   logic [dsp_pkg::ERR_W-1:0]      err;
   logic [dsp_pkg::ERR_W-1:0]      mag;
   logic                           snap;
   logic [dsp_pkg::ALPHA_W-1:0]    gain;
   logic [dsp_pkg::ERR_W-1:0]      step;
   logic [dsp_pkg::ERR_W-1:0]      new_cur;

   dsp_pkg::pu_ctl_type            pu_ctl;
   dsp_pkg::pu_sts_type            pu_sts;
   logic [dsp_pkg::PULSE_W-1:0]    pu_pulse;

   dsp_pulse_unit u_pulse (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pu_ctl),
      .min_pulse (min_ff),
      .max_pulse (max_ff),
      .sts       (pu_sts),
      .pulse_us  (pu_pulse)
   );

   assign req_fire  = req.valid && req.ready;
   assign ang_clamp = (req.angle_deg > dsp_pkg::MAX_ANGLE_DEG) ? dsp_pkg::MAX_ANGLE_DEG
                                                               : req.angle_deg;

   assign err  = {1'b0, tgt_ff, {dsp_pkg::Q_SHIFT{1'b0}}} - {1'b0, cur_ff};
   assign mag  = err[dsp_pkg::ERR_W-1] ? (~err + 1'b1) : err;
   assign snap = (mag <= {1'b0, thr_ff, {dsp_pkg::Q_SHIFT{1'b0}}});
   assign gain = (alpha_ff > dsp_pkg::ALPHA_ONE) ? dsp_pkg::ALPHA_ONE : alpha_ff;

   // arithmetic shift of the product gives the floor
   assign step    = acc_ff[dsp_pkg::PROD_W-1:dsp_pkg::Q_SHIFT];
   assign new_cur = {1'b0, cur_ff} + step;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  dsp_pkg::REQ_TICK:   if (damping_ff) state_in = dsp_pkg::ST_CHECK;
                  dsp_pkg::REQ_DIRECT: state_in = dsp_pkg::ST_PULSE;
                  default:             state_in = dsp_pkg::ST_IDLE;
               endcase
            end
         end
         dsp_pkg::ST_CHECK: state_in = snap ? dsp_pkg::ST_PULSE : dsp_pkg::ST_GAIN;
         dsp_pkg::ST_GAIN:  if (cnt_ff == dsp_pkg::GAIN_LAST) state_in = dsp_pkg::ST_MOVE;
         dsp_pkg::ST_MOVE:  state_in = dsp_pkg::ST_PULSE;
         dsp_pkg::ST_PULSE: if (load_rsp) state_in = dsp_pkg::ST_IDLE;
         default:           state_in = dsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready    = (state_ff == dsp_pkg::ST_IDLE);
      load_rsp     = (state_ff == dsp_pkg::ST_PULSE) && pu_sts.done
                     && (!rsp_valid_ff || rsp.ready);
      pu_ctl.ack   = load_rsp;
      pu_ctl.start = 1'b0;
      pu_ctl.angle = ang_clamp;
      unique case (state_ff)
         dsp_pkg::ST_IDLE: begin
            pu_ctl.start = req_fire && (req.req_type == dsp_pkg::REQ_DIRECT);
         end
         dsp_pkg::ST_CHECK: begin
            pu_ctl.start = snap;
            pu_ctl.angle = tgt_ff;
         end
         dsp_pkg::ST_MOVE: begin
            pu_ctl.start = 1'b1;
            pu_ctl.angle = new_cur[dsp_pkg::Q8_W-1:dsp_pkg::Q_SHIFT];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      damping_in = damping_ff;
      settled_in = settled_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         dsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req.req_type)
                  dsp_pkg::REQ_TARGET: begin
                     tgt_in     = ang_clamp;
                     damping_in = 1'b1;
                  end
                  dsp_pkg::REQ_DIRECT: settled_in = 1'b0;
                  default: begin
                  end
               endcase
            end
         end
         dsp_pkg::ST_CHECK: begin
            if (snap) begin
               cur_in     = {tgt_ff, {dsp_pkg::Q_SHIFT{1'b0}}};
               damping_in = 1'b0;
               settled_in = 1'b1;
            end else begin
               mcand_in  = {{(dsp_pkg::PROD_W - dsp_pkg::ERR_W){err[dsp_pkg::ERR_W-1]}}, err};
               mplier_in = gain;
               acc_in    = '0;
               cnt_in    = '0;
            end
         end
         dsp_pkg::ST_GAIN: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[dsp_pkg::PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[dsp_pkg::ALPHA_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
         end
         dsp_pkg::ST_MOVE: begin
            cur_in     = new_cur[dsp_pkg::Q8_W-1:0];
            settled_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_settled_in = rsp_settled_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_pulse_in   = pu_pulse;
         rsp_settled_in = settled_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.pulse_us = rsp_pulse_ff;
   assign rsp.settled  = rsp_settled_ff;
   assign csr.ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsp_pkg::ST_IDLE;
         cur_ff       <= {dsp_pkg::RESET_ANGLE_DEG, {dsp_pkg::Q_SHIFT{1'b0}}};
         tgt_ff       <= '0;
         damping_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= dsp_pkg::MIN_PULSE_RESET;
         max_ff       <= dsp_pkg::MAX_PULSE_RESET;
         alpha_ff     <= dsp_pkg::ALPHA_RESET;
         thr_ff       <= dsp_pkg::THR_RESET;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         damping_ff   <= damping_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               dsp_pkg::CSR_MIN_PULSE: min_ff   <= csr.data;
               dsp_pkg::CSR_MAX_PULSE: max_ff   <= csr.data;
               dsp_pkg::CSR_ALPHA:     alpha_ff <= csr.data[dsp_pkg::ALPHA_W-1:0];
               dsp_pkg::CSR_THRESHOLD: thr_ff   <= csr.data[dsp_pkg::THR_W-1:0];
               default: begin
               end
            endcase
         end
      end
      settled_ff     <= settled_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      acc_ff         <= acc_in;
      cnt_ff         <= cnt_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   // a snap lands exactly on the target and ends damping
   ast_snap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsp_pkg::ST_CHECK && snap) |=>
         (cur_ff == {tgt_ff, {dsp_pkg::Q_SHIFT{1'b0}}} && !damping_ff))
      else $error("snap did not land on target");

   // gain at most one, so a move never leaves the angle range
   ast_move_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsp_pkg::ST_MOVE) |=> (cur_ff <= dsp_pkg::MAX_ANGLE_Q8))
      else $error("current angle beyond range after move");

   ast_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      pu_sts.busy |-> !req.ready)
      else $error("request accepted while pulse unit busy");

   ast_target_arms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.req_type == dsp_pkg::REQ_TARGET) |=> damping_ff)
      else $error("set-target request did not arm damping");

endmodule

### tb/damped_servo_pulse_control_tb.sv
module damped_servo_pulse_control_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsp_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_us;
      logic               settled;
   } pulse_word_type;

   class servo_pulse_scoreboard;
      logic [PULSE_W-1:0]      min_pulse;
      logic [PULSE_W-1:0]      max_pulse;
      logic [ALPHA_W-1:0]      alpha;
      logic [THR_W-1:0]        threshold;
      logic signed [ERR_W-1:0] angle_now_q8;
      logic signed [ERR_W-1:0] target_q8;
      bit                      damping;
      pulse_word_type          expected_words[$];
      int                      errors;

      function new();
         min_pulse    = MIN_PULSE_RESET;
         max_pulse    = MAX_PULSE_RESET;
         alpha        = ALPHA_RESET;
         threshold    = THR_RESET;
         angle_now_q8 = {1'b0, RESET_ANGLE_DEG, {Q_SHIFT{1'b0}}};
         target_q8    = '0;
         damping      = 1'b0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MIN_PULSE: min_pulse = data;
            CSR_MAX_PULSE: max_pulse = data;
            CSR_ALPHA:     alpha = data[ALPHA_W-1:0];
            CSR_THRESHOLD: threshold = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [PULSE_W-1:0] pulse_width(logic [ANGLE_W-1:0] deg);
         logic [PULSE_W-1:0] span;
         logic [QUOT_W-1:0]  scaled;
         // inverted range collapses to the minimum width
         span   = (max_pulse >= min_pulse) ? max_pulse - min_pulse : '0;
         scaled = deg * span;
         return min_pulse + PULSE_W'(scaled / MAX_ANGLE_DEG);
      endfunction

      function void note_request(logic [1:0] kind, logic [ANGLE_W-1:0] angle_in);
         logic [ANGLE_W-1:0]       deg;
         logic signed [ERR_W-1:0]  err;
         logic [ERR_W-1:0]         mag;
         logic [ALPHA_W-1:0]       gain;
         logic signed [PROD_W-1:0] step;
         pulse_word_type           word;
         deg = (angle_in > MAX_ANGLE_DEG) ? MAX_ANGLE_DEG : angle_in;
         case (kind)
            REQ_TARGET: begin
               target_q8 = {1'b0, deg, {Q_SHIFT{1'b0}}};
               damping   = 1'b1;
            end
            REQ_DIRECT: begin
               word.pulse_us = pulse_width(deg);
               word.settled  = 1'b0;
               expected_words.push_back(word);
            end
            REQ_TICK: begin
               if (damping) begin
                  err = target_q8 - angle_now_q8;
                  mag = err[ERR_W-1] ? -err : err;
                  if (mag <= {threshold, {Q_SHIFT{1'b0}}}) begin
                     angle_now_q8 = target_q8;
                     damping      = 1'b0;
                     word.settled = 1'b1;
                  end else begin
                     gain = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
                     step = $signed({1'b0, gain}) * err;
                     // arithmetic shift floors toward minus infinity
                     angle_now_q8 = angle_now_q8 + ERR_W'(step >>> Q_SHIFT);
                     word.settled = 1'b0;
                  end
                  word.pulse_us = pulse_width(angle_now_q8[Q8_W-1:Q_SHIFT]);
                  expected_words.push_back(word);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [PULSE_W-1:0] pulse, logic settled);
         pulse_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: pulse_us %0d settled %0b", pulse, settled);
         end else begin
            want = expected_words.pop_front();
            if (want.pulse_us !== pulse || want.settled !== settled) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected pulse_us %0d settled %0b, got pulse_us %0d settled %0b",
                           want.pulse_us, want.settled, pulse, settled);
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   dsp_req_if req_if ();
   dsp_rsp_if rsp_if ();
   dsp_csr_if csr_if ();

   damped_servo_pulse_control u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   servo_pulse_scoreboard pulses = new();
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         pulses.check_word(rsp_if.pulse_us, rsp_if.settled);
   end

   task automatic send_request(input logic [1:0] kind, input logic [ANGLE_W-1:0] angle);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.angle_deg <= angle;
      do @(posedge clock); while (!req_if.ready);
      pulses.note_request(kind, angle);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      pulses.write_reg(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic write_setting(input logic [15:0] min_us, input logic [15:0] max_us,
                                input logic [15:0] gain, input logic [15:0] thr);
      write_csr(CSR_MIN_PULSE, min_us);
      write_csr(CSR_MAX_PULSE, max_us);
      write_csr(CSR_ALPHA, gain);
      write_csr(CSR_THRESHOLD, thr);
   endtask

   // drop valid, drain every expected word, then give a word-less item time to finish
   task automatic settle_down();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pulses.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // a target followed by a run of ticks that walks towards it
            if ($urandom_range(9) == 0)
               send_request(REQ_TARGET, 8'($urandom_range(255)));
            else
               send_request(REQ_TARGET, 8'($urandom_range(180)));
            burst = $urandom_range(40, 1);
            repeat (burst) send_request(REQ_TICK, 8'($urandom));
            sent += burst + 1;
         end else if (pick < 80) begin
            send_request(REQ_DIRECT, 8'($urandom));
            sent++;
         end else if (pick < 92) begin
            send_request(REQ_TICK, 8'($urandom));
            sent++;
         end else begin
            send_request(REQ_UNUSED, 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      int phase;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_TARGET;
      req_if.angle_deg = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_MIN_PULSE;
      csr_if.data      = '0;
      rsp_if.ready     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_setting(16'd800, 16'd2200, 16'd128, 16'd10);
      send_request(REQ_TICK, 8'hFF);
      send_request(REQ_UNUSED, 8'h00);
      send_request(REQ_UNUSED, 8'hFF);
      send_request(REQ_DIRECT, 8'd0);
      send_request(REQ_DIRECT, 8'd180);
      send_request(REQ_DIRECT, 8'd181);
      send_request(REQ_DIRECT, 8'd255);
      send_request(REQ_DIRECT, 8'h55);
      // clamped target, then ticks whose angle must be ignored
      send_request(REQ_TARGET, 8'd255);
      repeat (3) begin
         send_request(REQ_TICK, 8'h55);
         send_request(REQ_TICK, 8'hAA);
      end
      // downward move exercises the flooring of negative steps
      send_request(REQ_TARGET, 8'd3);
      repeat (7) send_request(REQ_TICK, 8'hAA);
      settle_down();

      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: write_setting(MIN_PULSE_RESET, MAX_PULSE_RESET, 16'(ALPHA_RESET),
                             16'(THR_RESET));
            1: write_setting(16'd0, 16'hFFFF, 16'd256, 16'd0);
            2: write_setting(16'hFFFF, 16'd0, 16'd511, 16'd180);
            3: write_setting(16'd0, 16'd0, 16'd0, 16'd0);
            4: write_setting(16'hFFFF, 16'hFFFF, 16'd1, 16'd255);
            default: begin
               write_setting(16'($urandom), 16'($urandom),
                             $urandom_range(1) ? 16'($urandom_range(300)) : 16'($urandom),
                             $urandom_range(1) ? 16'($urandom_range(180)) : 16'($urandom));
            end
         endcase
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 46;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 46;
            end
            default: begin
               send_idle_pct  = 24;
               recv_stall_pct = 24;
            end
         endcase
         run_random(123);
         settle_down();
      end

      if (pulses.errors == 0 && pulses.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
